// File: hdl/cscull_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cscull_pkg: shared types and constants for the cylinder screen cull core
// Display size, list depth, register indexes, sequencer states and the
// fixed-point helper used by the core.
// ----------------------------------------------------------------------------
package cscull_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 160;
  localparam int MAX_VISIBLE   = 1024;

  localparam int HALF_W = SCREEN_WIDTH / 2;
  localparam int HALF_H = SCREEN_HEIGHT / 2;

  // field widths
  localparam int IDX_W   = 16;
  localparam int COORD_W = 32;
  localparam int RAD_W   = 10;
  localparam int SLOT_W  = 10;
  localparam int SCALE_W = 31;
  localparam int REL_W   = COORD_W - 4;          // after the divide by 16
  localparam int PROD_W  = 2 * COORD_W;
  localparam int SCR_W   = PROD_W - 16;          // screen coordinate
  localparam int CHK_W   = SCR_W + 1;            // screen coordinate +/- radius
  localparam int CNT_W   = $clog2(MAX_VISIBLE + 1);

  localparam int IN_DATA_W  = 96;                // 90 bits of fields, byte padded
  localparam int OUT_DATA_W = 32;                // 26 bits of fields, byte padded
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CAM_POS_X  = 3'd0,
    REG_CAM_POS_Z  = 3'd1,
    REG_AXIS_U_X   = 3'd2,
    REG_AXIS_U_Z   = 3'd3,
    REG_AXIS_V_X   = 3'd4,
    REG_AXIS_V_Z   = 3'd5,
    REG_PROJ_SCALE = 3'd6
  } reg_index_t;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_REL  = 10'b00_0000_0010,
    S_M0   = 10'b00_0000_0100,
    S_M1   = 10'b00_0000_1000,
    S_M2   = 10'b00_0001_0000,
    S_M3   = 10'b00_0010_0000,
    S_M4   = 10'b00_0100_0000,
    S_M5   = 10'b00_1000_0000,
    S_SX   = 10'b01_0000_0000,
    S_FIN  = 10'b10_0000_0000
  } state_t;

  // signed divide by 16, truncating toward zero
  function automatic logic signed [REL_W-1:0] div16_trunc(
    input logic signed [COORD_W-1:0] d
  );
    logic [COORD_W-1:0] biased;
    biased = d + (d[COORD_W-1] ? COORD_W'(15) : COORD_W'(0));
    return signed'(biased[COORD_W-1:4]);
  endfunction

endpackage
`default_nettype wire

// File: hdl/cylinder_screen_cull_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cylinder_screen_cull_core: bounding-circle screen cull of vertical cylinders
// Usage:
//   Input words arrive on the s_ group: tdata carries model index, centroid
//   x/z (Q19.12) and radius; tlast marks the last cylinder of a cell.
//   A word that lands on the display while the visible list has room goes
//   out on the m_ group with model index and slot; tlast copies the cell mark.
//   The user must write camera position, axes and projection scale on cfg_we/
//   cfg_addr/cfg_data port only while the core is idle, unchecked by the core.
// Sequence:
//   One cylinder passes through these steps: accept, relative position, six
//   passes of the single shared 32x32 multiplier, y/x checks and the final
//   decision. The output word sits in its own register, so the next
//   cylinder is taken while it waits; the core only holds in its last step
//   when a new result meets an output word the receiver has not yet taken.
// Reset:
//   rst clears the slot counter, the output valid and the sequencer, and
//   loads a zero camera position, identity camera axes and a zero scale.
// ----------------------------------------------------------------------------
module cylinder_screen_cull_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // config write port
  input  wire logic                               cfg_we,
  input  wire logic [cscull_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [cscull_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // [15:0] cyl_idx, [47:16] cyl_x, [79:48] cyl_z, [89:80] radius
  input  wire logic [cscull_pkg::IN_DATA_W-1:0]   s_tdata,
  input  wire logic                               s_tlast,
  // output stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [15:0] visible_index, [25:16] slot
  output logic [cscull_pkg::OUT_DATA_W-1:0]       m_tdata,
  output logic                                    m_tlast
);
  import cscull_pkg::*;

  // configuration
  logic signed [COORD_W-1:0] cam_pos_x, cam_pos_z;
  logic signed [COORD_W-1:0] axis_u_x, axis_u_z, axis_v_x, axis_v_z;
  logic        [SCALE_W-1:0] proj_scale;

  // captured word
  logic        [IDX_W-1:0]   item_idx;
  logic signed [COORD_W-1:0] item_cx, item_cz;
  logic        [RAD_W-1:0]   item_rad;
  logic                      item_last;

  // datapath
  state_t                    state;
  logic signed [REL_W-1:0]   rel_x, rel_z;
  logic signed [COORD_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic        [COORD_W-1:0] vsum, usum;
  logic signed [SCR_W-1:0]   scr_y, scr_x, scr_shift;
  logic                      vis_y;
  logic                      vis_x;
  logic                      emit;
  logic                      out_free;
  logic        [CNT_W-1:0]   visible_count;
  logic        [COORD_W-1:0] prod_fx;
  logic signed [CHK_W-1:0]   chk_lo, chk_hi;
  logic signed [SCR_W-1:0]   chk_src;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign prod_fx  = prod[COORD_W+11:12];
  assign scr_shift = signed'(prod[PROD_W-1:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_pos_x  <= '0;
      cam_pos_z  <= '0;
      axis_u_x   <= COORD_W'(4096);
      axis_u_z   <= '0;
      axis_v_x   <= '0;
      axis_v_z   <= COORD_W'(4096);
      proj_scale <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CAM_POS_X:  cam_pos_x  <= signed'(cfg_data);
        REG_CAM_POS_Z:  cam_pos_z  <= signed'(cfg_data);
        REG_AXIS_U_X:   axis_u_x   <= signed'(cfg_data);
        REG_AXIS_U_Z:   axis_u_z   <= signed'(cfg_data);
        REG_AXIS_V_X:   axis_v_x   <= signed'(cfg_data);
        REG_AXIS_V_Z:   axis_v_z   <= signed'(cfg_data);
        REG_PROJ_SCALE: proj_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_M0: begin mul_a = COORD_W'(rel_x); mul_b = axis_v_x; end
      S_M1: begin mul_a = COORD_W'(rel_z); mul_b = axis_v_z; end
      S_M2: begin mul_a = COORD_W'(rel_x); mul_b = axis_u_x; end
      S_M3: begin mul_a = COORD_W'(rel_z); mul_b = axis_u_z; end
      S_M4: begin mul_a = signed'(COORD_W'(0) - vsum); mul_b = signed'({1'b0, proj_scale}); end
      S_M5: begin mul_a = signed'(usum); mul_b = signed'({1'b0, proj_scale}); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // overlap test: coord + r >= 0 and coord - r < size
  always_comb begin
    chk_src = (state == S_SX) ? scr_y : scr_x;
    chk_lo  = CHK_W'(chk_src) + signed'(CHK_W'(item_rad));
    chk_hi  = CHK_W'(chk_src) - signed'(CHK_W'(item_rad));
    if (state == S_SX) begin
      vis_x = 1'b0;
    end else begin
      vis_x = (chk_lo >= 0) && (chk_hi < signed'(CHK_W'(SCREEN_WIDTH)));
    end
    emit = vis_y && vis_x && (visible_count < CNT_W'(MAX_VISIBLE));
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        item_idx  <= s_tdata[15:0];
        item_cx   <= signed'(s_tdata[47:16]);
        item_cz   <= signed'(s_tdata[79:48]);
        item_rad  <= s_tdata[89:80];
        item_last <= s_tlast;
      end
      S_REL: begin
        rel_x <= div16_trunc(item_cx - cam_pos_x);
        rel_z <= div16_trunc(item_cz - cam_pos_z);
      end
      S_M1: vsum <= prod_fx;
      S_M2: vsum <= vsum + prod_fx;
      S_M3: usum <= prod_fx;
      S_M4: usum <= usum + prod_fx;
      S_M5: scr_y <= scr_shift + SCR_W'(HALF_H);
      S_SX: begin
        scr_x <= scr_shift + SCR_W'(HALF_W);
        vis_y <= (chk_lo >= 0) && (chk_hi < signed'(CHK_W'(SCREEN_HEIGHT)));
      end
      default: ;
    endcase
  end

  // sequencer, counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      visible_count <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (state == S_FIN && emit && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (s_tvalid) state <= S_REL;
        S_REL:  state <= S_M0;
        S_M0:   state <= S_M1;
        S_M1:   state <= S_M2;
        S_M2:   state <= S_M3;
        S_M3:   state <= S_M4;
        S_M4:   state <= S_M5;
        S_M5:   state <= S_SX;
        S_SX:   state <= S_FIN;
        S_FIN: begin
          if (!emit || out_free) begin
            if (emit) begin
              m_tdata  <= {{(OUT_DATA_W - IDX_W - SLOT_W){1'b0}},
                           visible_count[SLOT_W-1:0], item_idx};
              m_tlast  <= item_last;
            end
            if (item_last) begin
              visible_count <= '0;
            end else if (emit) begin
              visible_count <= visible_count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    visible_count <= CNT_W'(MAX_VISIBLE))
    else $error("visible count past list depth");

  a_count_only_at_fin: assert property (@(posedge clk) disable iff (rst)
    (state != S_FIN) |=> $stable(visible_count))
    else $error("visible count changed outside final step");

  a_out_load_only_at_fin: assert property (@(posedge clk) disable iff (rst)
    (state != S_FIN) |=> (!m_tvalid || $stable(m_tdata)))
    else $error("output word changed outside final step");
`endif

endmodule
`default_nettype wire

// File: dv/cylinder_screen_cull_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylinder_screen_cull_core_tb: self-checking bench for the cylinder cull core
// Streams cylinders into the core under several camera setups and compares
// every visible word against an in-bench projection and cull predictor. It
// covers the display edges, the truncating divide, the full visible list and
// cell ends, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module cylinder_screen_cull_core_tb;
  import cscull_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cz;
    logic [RAD_W-1:0]          radius;
    logic                      last;
  } cylinder_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [SLOT_W-1:0] slot;
    logic              done;
  } visible_word_t;

  typedef struct {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] u_x;
    logic signed [COORD_W-1:0] u_z;
    logic signed [COORD_W-1:0] v_x;
    logic signed [COORD_W-1:0] v_z;
    logic [CFG_DATA_W-1:0]     scale;   // raw value written to the register
  } camera_t;

  typedef enum int {
    CAM_IDENTITY,
    CAM_SMALL_AXES,
    CAM_EXTREME_HI,
    CAM_EXTREME_LO,
    CAM_RANDOM,
    CAM_KINDS
  } camera_kind_t;

  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q12_ONE = 32'd4096;
  localparam logic [31:0] SCALE_ONE = 32'h0001_0000;
  localparam int SETTLE_CYCLES = 16;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  // predictor state
  camera_t       cam_regs;
  int            slot_count;
  visible_word_t pending_visible[$];

  int errors;
  int send_idle_pct;
  int take_idle_pct;
  int camera_phase;

  cylinder_screen_cull_core uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [15:0] cyl_idx, [47:16] cyl_x,
                            // [79:48] cyl_z, [89:80] radius
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [15:0] visible_index, [25:16] slot
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("cylinder_screen_cull_core_tb: done, errors");
    $finish;
  end

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // (a*b)>>12 at full width, cut to 32 bits
  function automatic logic [31:0] q12_mul(input longint a, input longint b);
    longint p;
    p = (a * b) >>> 12;
    return p[31:0];
  endfunction

  function automatic void project_and_cull(input cylinder_t c);
    logic signed [31:0] dx, dz, ucx, vcy;
    logic [31:0]        vsum;
    longint             rx, rz, sx, sy, rad;
    visible_word_t      w;
    dx = c.cx - cam_regs.pos_x;
    dz = c.cz - cam_regs.pos_z;
    rx = longint'(dx) / 16;     // truncates toward zero
    rz = longint'(dz) / 16;
    vsum = q12_mul(rx, longint'(cam_regs.v_x)) + q12_mul(rz, longint'(cam_regs.v_z));
    vcy = -vsum;
    ucx = q12_mul(rx, longint'(cam_regs.u_x)) + q12_mul(rz, longint'(cam_regs.u_z));
    sy = ((longint'(vcy) * longint'(cam_regs.scale)) >>> 16) + HALF_H;
    sx = ((longint'(ucx) * longint'(cam_regs.scale)) >>> 16) + HALF_W;
    rad = longint'(c.radius);
    if (sy + rad >= 0 && sy - rad < SCREEN_HEIGHT &&
        sx + rad >= 0 && sx - rad < SCREEN_WIDTH && slot_count < MAX_VISIBLE) begin
      w.idx  = c.idx;
      w.slot = SLOT_W'(slot_count);
      w.done = c.last;
      pending_visible.push_back(w);
      slot_count++;
    end
    if (c.last) slot_count = 0;
  endfunction

  function automatic void check_visible_word(input logic [IDX_W-1:0] idx,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic done);
    visible_word_t w;
    if (pending_visible.size() == 0) begin
      note_error($sformatf("unexpected word: idx %0d slot %0d done %0b", idx, slot, done));
      return;
    end
    w = pending_visible.pop_front();
    if (idx !== w.idx)
      note_error($sformatf("visible_index: expected %0d, got %0d", w.idx, idx));
    if (slot !== w.slot)
      note_error($sformatf("slot (idx %0d): expected %0d, got %0d", w.idx, w.slot, slot));
    if (done !== w.done)
      note_error($sformatf("cell_done (idx %0d): expected %0b, got %0b", w.idx, w.done, done));
  endfunction

  // output side: check, then pick the next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      check_visible_word(m_tdata[15:0], m_tdata[25:16], m_tlast);
    m_tready <= ($urandom_range(99) >= take_idle_pct);
  end

  task automatic send_cylinder(input cylinder_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, c.radius, c.cz, c.cx, c.idx};
    s_tlast  <= c.last;
    do @(posedge clk); while (!s_tready);
    project_and_cull(c);
  endtask

  // hold the input until every visible word is out, then let the core settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_visible.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t r, input logic [31:0] v);
    cfg_we   <= 1'b1;
    cfg_addr <= r;
    cfg_data <= v;
    case (r)
      REG_CAM_POS_X:  cam_regs.pos_x = v;
      REG_CAM_POS_Z:  cam_regs.pos_z = v;
      REG_AXIS_U_X:   cam_regs.u_x = v;
      REG_AXIS_U_Z:   cam_regs.u_z = v;
      REG_AXIS_V_X:   cam_regs.v_x = v;
      REG_AXIS_V_Z:   cam_regs.v_z = v;
      REG_PROJ_SCALE: cam_regs.scale = {1'b0, v[30:0]};
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_camera(input camera_t c);
    write_reg(REG_CAM_POS_X, c.pos_x);
    write_reg(REG_CAM_POS_Z, c.pos_z);
    write_reg(REG_AXIS_U_X, c.u_x);
    write_reg(REG_AXIS_U_Z, c.u_z);
    write_reg(REG_AXIS_V_X, c.v_x);
    write_reg(REG_AXIS_V_Z, c.v_z);
    write_reg(REG_PROJ_SCALE, c.scale);
    cfg_we <= 1'b0;
  endtask

  function automatic camera_t pick_camera(input camera_kind_t kind);
    camera_t c;
    c.pos_x = 0;
    c.pos_z = 0;
    c.u_x = Q12_ONE;
    c.u_z = 0;
    c.v_x = 0;
    c.v_z = Q12_ONE;
    c.scale = SCALE_ONE;
    case (kind)
      CAM_IDENTITY: begin
        c.pos_x = $urandom;
        c.pos_z = $urandom;
      end
      CAM_SMALL_AXES: begin
        c.pos_x = $urandom;
        c.pos_z = $urandom;
        c.u_x = $urandom_range(0, 16383) - 8192;
        c.u_z = $urandom_range(0, 16383) - 8192;
        c.v_x = $urandom_range(0, 16383) - 8192;
        c.v_z = $urandom_range(0, 16383) - 8192;
        c.scale = $urandom_range(4096, 524288);
      end
      CAM_EXTREME_HI: begin
        c.pos_x = INT_MIN;
        c.pos_z = INT_MAX;
        c.u_x = INT_MIN;
        c.u_z = INT_MAX;
        c.v_x = INT_MAX;
        c.v_z = INT_MIN;
        c.scale = 32'hFFFF_FFFF;   // top bit is dropped by the register
      end
      CAM_EXTREME_LO: begin
        c.pos_x = INT_MAX;
        c.pos_z = INT_MIN;
        c.u_x = INT_MAX;
        c.u_z = INT_MIN;
        c.v_x = INT_MIN;
        c.v_z = INT_MAX;
        c.scale = INT_MIN;         // masks to a zero scale
      end
      default: begin
        c.pos_x = $urandom;
        c.pos_z = $urandom;
        c.u_x = $urandom;
        c.u_z = $urandom;
        c.v_x = $urandom;
        c.v_z = $urandom;
        c.scale = $urandom;
      end
    endcase
    return c;
  endfunction

  function automatic cylinder_t make_cyl(input logic [IDX_W-1:0] idx,
                                         input logic [31:0] cx, input logic [31:0] cz,
                                         input logic [RAD_W-1:0] radius, input logic last);
    cylinder_t c;
    c.idx = idx;
    c.cx = cx;
    c.cz = cz;
    c.radius = radius;
    c.last = last;
    return c;
  endfunction

  // near: centroid offset from the camera by a random number of bits
  function automatic cylinder_t gen_cylinder(input bit near);
    cylinder_t          c;
    logic signed [31:0] ox, oz;
    int                 kx, kz;
    c.idx = IDX_W'($urandom);
    c.radius = $urandom_range(1) ? RAD_W'($urandom_range(0, 40))
                                 : RAD_W'($urandom_range(0, 1023));
    c.last = ($urandom_range(99) < 8);
    if (near) begin
      kx = $urandom_range(4, 24);
      kz = $urandom_range(4, 24);
      ox = $urandom;
      oz = $urandom;
      ox = ox <<< (32 - kx);
      ox = ox >>> (32 - kx);
      oz = oz <<< (32 - kz);
      oz = oz >>> (32 - kz);
      c.cx = cam_regs.pos_x + ox;
      c.cz = cam_regs.pos_z + oz;
    end else begin
      c.cx = $urandom;
      c.cz = $urandom;
    end
    return c;
  endfunction

  task automatic test_directed();
    camera_t c;
    // zero scale after reset: every cylinder lands on the center
    send_cylinder(make_cyl(16'd0, 32'd0, 32'd0, 10'd0, 1'b0));
    send_cylinder(make_cyl(16'hFFFF, INT_MAX, INT_MIN, 10'd1023, 1'b1));
    drain_results();
    c = pick_camera(CAM_IDENTITY);
    c.pos_x = 0;
    c.pos_z = 0;
    load_camera(c);
    // one pixel per 16 units: right, left, bottom and top edges with radius 5
    send_cylinder(make_cyl(16'd10, 32'd1984, 32'd0, 10'd5, 1'b0));
    send_cylinder(make_cyl(16'd11, 32'd2000, 32'd0, 10'd5, 1'b0));
    send_cylinder(make_cyl(16'd12, -32'sd2000, 32'd0, 10'd5, 1'b0));
    send_cylinder(make_cyl(16'd13, -32'sd2016, 32'd0, 10'd5, 1'b0));
    // -2001/16 must round toward zero to stay on screen
    send_cylinder(make_cyl(16'd14, -32'sd2001, 32'd0, 10'd5, 1'b0));
    send_cylinder(make_cyl(16'd15, 32'd0, -32'sd1344, 10'd5, 1'b0));
    send_cylinder(make_cyl(16'd16, 32'd0, -32'sd1360, 10'd5, 1'b0));
    send_cylinder(make_cyl(16'd17, 32'd0, 32'd1360, 10'd5, 1'b0));
    send_cylinder(make_cyl(16'd18, 32'd0, 32'd1376, 10'd5, 1'b0));
    send_cylinder(make_cyl(16'd19, 32'd17600, 32'd0, 10'd1023, 1'b0));
    // off-screen last cylinder still clears the slot counter
    send_cylinder(make_cyl(16'd20, 32'd32000, 32'd0, 10'd0, 1'b1));
    send_cylinder(make_cyl(16'd21, 32'd0, 32'd0, 10'd0, 1'b0));
    send_cylinder(make_cyl(16'd22, 32'd16, -32'sd16, 10'd1, 1'b1));
    send_cylinder(make_cyl(16'd23, 32'd0, 32'd0, 10'd0, 1'b1));
    drain_results();
  endtask

  // zero scale, so everything is visible: fill the list past its depth
  task automatic test_full_list();
    cylinder_t c;
    camera_t   cam;
    cam = pick_camera(CAM_IDENTITY);
    cam.scale = '0;
    load_camera(cam);
    for (int i = 0; i < MAX_VISIBLE + 6; i++) begin
      c = gen_cylinder(1'b0);
      c.last = 1'b0;
      send_cylinder(c);
    end
    c = gen_cylinder(1'b0);
    c.last = 1'b1;
    send_cylinder(c);
    send_cylinder(gen_cylinder(1'b0));
    send_cylinder(gen_cylinder(1'b0));
    drain_results();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) begin
        drain_results();
        load_camera(pick_camera(camera_kind_t'(camera_phase % CAM_KINDS)));
        camera_phase++;
      end
      send_cylinder(gen_cylinder($urandom_range(99) < 80));
    end
    drain_results();
  endtask

  initial begin
    int cap;
    errors = 0;
    slot_count = 0;
    camera_phase = 0;
    send_idle_pct = 21;
    take_idle_pct = 77;
    cam_regs = pick_camera(CAM_IDENTITY);
    cam_regs.pos_x = 0;
    cam_regs.pos_z = 0;
    cam_regs.scale = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(50);
    send_idle_pct = 77;
    take_idle_pct = 21;
    test_full_list();
    test_random(50);
    send_idle_pct = 0;
    take_idle_pct = 0;
    test_random(50);

    s_tvalid <= 1'b0;
    cap = 0;
    while (pending_visible.size() != 0 && cap < 20000) begin
      @(posedge clk);
      cap++;
    end
    repeat (30) @(posedge clk);
    if (pending_visible.size() != 0)
      note_error($sformatf("%0d visible words never arrived", pending_visible.size()));
    if (errors == 0) begin
      $display("cylinder_screen_cull_core_tb: done, clean");
    end else begin
      $display("cylinder_screen_cull_core_tb: done, errors");
    end
    $finish;
  end

endmodule
